// File: rtl/aff_sqrt_pkg.sv
// Shared types, constants and helpers for the affine transform square root.
package aff_sqrt_pkg;

  localparam int unsigned WORD_WIDTH       = 32;
  localparam int unsigned MATRIX_FRAC_BITS = 24;

  // Quotient bits kept before saturation, and the pre-shift that tests it.
  localparam int unsigned QUO_W     = WORD_WIDTH - 1;
  localparam int unsigned SAT_SHIFT = QUO_W - MATRIX_FRAC_BITS;

  // Square root cells: radicand, partial root and remainder widths.
  localparam int unsigned RAD_W    = 2 * WORD_WIDTH;
  localparam int unsigned ROOT_W   = WORD_WIDTH;
  localparam int unsigned SQ_REM_W = ROOT_W + 3;
  localparam int unsigned SQ_STEPS = RAD_W / 2;

  // Divider cells: remainder and divisor width, wide enough for det(m + I).
  localparam int unsigned DIV_W = 2 * WORD_WIDTH + 2;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NEG_DET,
    ST_TRACE,
    ST_SINGULAR
  } status_e;

  typedef struct packed {
    word_t mat_a;
    word_t mat_b;
    word_t mat_c;
    word_t mat_d;
    word_t shift_x;
    word_t shift_y;
  } in_t;

  typedef struct packed {
    word_t   root_a;
    word_t   root_b;
    word_t   root_c;
    word_t   root_d;
    word_t   root_shift_x;
    word_t   root_shift_y;
    status_e status;
  } out_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [QUO_W-1:0] tail;
    logic [QUO_W-1:0] quo;
  } dv_t;

  // Sign and saturate a quotient magnitude into one word.
  function automatic word_t sat_word(input logic neg, input logic sat,
                                     input logic [QUO_W-1:0] quo);
    word_t res;
    if (sat) begin
      res = neg ? word_t'({1'b1, {QUO_W{1'b0}}}) : word_t'({1'b0, {QUO_W{1'b1}}});
    end else if (neg) begin
      res = -$signed({1'b0, quo});
    end else begin
      res = $signed({1'b0, quo});
    end
    return res;
  endfunction

endpackage

// File: rtl/aff_sqrt_sqrt_cell.sv
// One restoring square root cell: two radicand bits in, one root bit out.
module aff_sqrt_sqrt_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  aff_sqrt_pkg::sq_t   d_i,
  output aff_sqrt_pkg::sq_t   q_o
);

  logic [aff_sqrt_pkg::SQ_REM_W-1:0] part;
  logic [aff_sqrt_pkg::SQ_REM_W-1:0] trial;
  logic                              take;
  aff_sqrt_pkg::sq_t                 cell_d, cell_q;

  assign part  = {d_i.rem[aff_sqrt_pkg::SQ_REM_W-3:0],
                  d_i.rad[aff_sqrt_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, d_i.root, 2'b01};
  assign take  = (part >= trial);

  always_comb begin
    cell_d.rad  = {d_i.rad[aff_sqrt_pkg::RAD_W-3:0], 2'b00};
    cell_d.rem  = take ? (part - trial) : part;
    cell_d.root = {d_i.root[aff_sqrt_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// File: rtl/aff_sqrt_div_cell.sv
// One restoring divider cell: one dividend bit in, one quotient bit out.
module aff_sqrt_div_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  aff_sqrt_pkg::dv_t d_i,
  output aff_sqrt_pkg::dv_t q_o
);

  logic [aff_sqrt_pkg::DIV_W:0] part;
  logic [aff_sqrt_pkg::DIV_W:0] diff;
  logic                         take;
  aff_sqrt_pkg::dv_t            cell_d, cell_q;

  assign part = {d_i.rem, d_i.tail[aff_sqrt_pkg::QUO_W-1]};
  assign diff = part - {1'b0, d_i.den};
  assign take = (part >= {1'b0, d_i.den});

  always_comb begin
    cell_d.rem  = take ? diff[aff_sqrt_pkg::DIV_W-1:0] : part[aff_sqrt_pkg::DIV_W-1:0];
    cell_d.den  = d_i.den;
    cell_d.tail = {d_i.tail[aff_sqrt_pkg::QUO_W-2:0], 1'b0};
    cell_d.quo  = {d_i.quo[aff_sqrt_pkg::QUO_W-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// File: rtl/affine2d_transform_sqrt.sv
// Top level: square root of a 2D affine transform, fully pipelined.
//
// Takes a 2x2 matrix (Q8.24) and an offset (Q16.16) per beat and returns the
// root transform r with r(r(v)) = M v + O, plus a status code. The matrix root
// is (M + sI) / t with s = sqrt(det M) and t = sqrt(trace M + 2s); the root
// offset is (m + I)^-1 O. Results saturate; on a negative determinant, a trace
// term that is not positive, or a singular m + I, all fields are zero and the
// status names the case (earliest check wins). One beat is taken every clock
// while the pipe is not held. The pipe is built from two chains of 32 square
// root cells (one root bit each) and two chains of 31 divider cells (one
// quotient bit each), plus ten single register stages for the multiplies,
// adds and sign/saturation work. The whole pipe advances together and holds
// only while the output register has a beat that the receiver stalls, so
// in_stall_o follows out_stall_i in that case.
module affine2d_transform_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aff_sqrt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aff_sqrt_pkg::out_t out_data_o
);

  localparam int unsigned W     = aff_sqrt_pkg::WORD_WIDTH;
  localparam int unsigned MF    = aff_sqrt_pkg::MATRIX_FRAC_BITS;
  localparam int unsigned QW    = aff_sqrt_pkg::QUO_W;
  localparam int unsigned SSH   = aff_sqrt_pkg::SAT_SHIFT;
  localparam int unsigned RW    = aff_sqrt_pkg::RAD_W;
  localparam int unsigned TW    = aff_sqrt_pkg::ROOT_W;
  localparam int unsigned DW    = aff_sqrt_pkg::DIV_W;
  localparam int unsigned NSQ   = aff_sqrt_pkg::SQ_STEPS;
  localparam int unsigned TR_W  = W + 3;       // trace term a + d + 2s
  localparam int unsigned X_W   = W + 2;       // diagonal plus s
  localparam int unsigned P_W   = W + 1;       // m + I diagonal
  localparam int unsigned PW    = DW;          // products and their differences
  localparam int unsigned CMP_W = DW + SSH;    // saturation compares

  localparam logic signed [P_W-1:0] ONE_P = P_W'(1) << MF;

  // Sidecar bundles riding along the cell chains.
  typedef struct packed {
    aff_sqrt_pkg::in_t side;
    logic              neg;
  } c1_t;

  typedef struct packed {
    aff_sqrt_pkg::in_t     side;
    logic [TW-1:0]         s;
    aff_sqrt_pkg::status_e st;
  } c2_t;

  typedef struct packed {
    logic [3:0]            neg;
    logic [3:0]            sat;
    aff_sqrt_pkg::word_t   ox;
    aff_sqrt_pkg::word_t   oy;
    aff_sqrt_pkg::status_e st;
  } c3_t;

  typedef struct packed {
    aff_sqrt_pkg::word_t [3:0] m;
    logic [1:0]                neg;
    logic [1:0]                sat;
    aff_sqrt_pkg::status_e     st;
  } c4_t;

  logic en;
  logic vout_q;

  // Whole pipe moves unless the output beat is held.
  assign en          = !(vout_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vout_q;

  // ---------------------------------------------------------------------------
  // Stage 0..2: input register, det products, determinant.
  // ---------------------------------------------------------------------------
  logic                          v0_q, v1_q, v2_q;
  aff_sqrt_pkg::in_t             in0_q, side1_q, side2_q;
  logic signed [2*W-1:0]         ad1_q, bc1_q;
  logic signed [2*W:0]           det2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in0_q   <= in_data_i;
      ad1_q   <= in0_q.mat_a * in0_q.mat_d;
      bc1_q   <= in0_q.mat_b * in0_q.mat_c;
      side1_q <= in0_q;
      det2_q  <= (2*W+1)'(ad1_q) - (2*W+1)'(bc1_q);
      side2_q <= side1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Chain 1: s = floor(sqrt(det)).
  // ---------------------------------------------------------------------------
  aff_sqrt_pkg::sq_t c1_sq [NSQ+1];
  c1_t               c1_side_q [NSQ];
  logic [NSQ-1:0]    c1_v_q;

  assign c1_sq[0] = '{rad: det2_q[RW-1:0], rem: '0, root: '0};

  for (genvar g = 0; g < NSQ; g++) begin : g_sq1
    aff_sqrt_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (c1_sq[g]),
      .q_o   (c1_sq[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_side_q[0] <= '{side: side2_q, neg: det2_q[2*W]};
      for (int i = 1; i < NSQ; i++) begin
        c1_side_q[i] <= c1_side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: trace term and its root radicand.
  // ---------------------------------------------------------------------------
  c1_t                     c1_out;
  logic [TW-1:0]           s1;
  logic signed [TR_W-1:0]  tr3_d, tr3_q;
  aff_sqrt_pkg::status_e   st3_d, st3_q;
  aff_sqrt_pkg::in_t       side3_q;
  logic [TW-1:0]           s3_q;
  logic                    v3_q;

  assign c1_out = c1_side_q[NSQ-1];
  assign s1     = c1_sq[NSQ].root;

  always_comb begin
    tr3_d = TR_W'(c1_out.side.mat_a) + TR_W'(c1_out.side.mat_d)
          + $signed({2'b00, s1, 1'b0});
    if (c1_out.neg) begin
      st3_d = aff_sqrt_pkg::ST_NEG_DET;
    end else if (tr3_d[TR_W-1] || (tr3_d == TR_W'(0))) begin
      st3_d = aff_sqrt_pkg::ST_TRACE;
    end else begin
      st3_d = aff_sqrt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr3_q   <= tr3_d;
      st3_q   <= st3_d;
      side3_q <= c1_out.side;
      s3_q    <= s1;
    end
  end

  // ---------------------------------------------------------------------------
  // Chain 2: t = floor(sqrt(T * 2^F)).
  // ---------------------------------------------------------------------------
  aff_sqrt_pkg::sq_t c2_sq [NSQ+1];
  c2_t               c2_side_q [NSQ];
  logic [NSQ-1:0]    c2_v_q;

  assign c2_sq[0] = '{rad: RW'($unsigned(tr3_q)) << MF, rem: '0, root: '0};

  for (genvar g = 0; g < NSQ; g++) begin : g_sq2
    aff_sqrt_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (c2_sq[g]),
      .q_o   (c2_sq[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_side_q[0] <= '{side: side3_q, s: s3_q, st: st3_q};
      for (int i = 1; i < NSQ; i++) begin
        c2_side_q[i] <= c2_side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: four matrix lanes, magnitude, saturation test, divider setup.
  // ---------------------------------------------------------------------------
  c2_t                         c2_out;
  logic [TW-1:0]               t2;
  logic signed [X_W-1:0]       xv   [4];
  logic [X_W-1:0]              xmag [4];
  aff_sqrt_pkg::dv_t           dv4_d [4];
  aff_sqrt_pkg::dv_t           dv4_q [4];
  logic [3:0]                  mneg4_d, msat4_d;
  c3_t                         side4_q;
  logic                        v4_q;

  assign c2_out = c2_side_q[NSQ-1];
  assign t2     = c2_sq[NSQ].root;

  always_comb begin
    xv[0] = X_W'(c2_out.side.mat_a) + $signed({2'b00, c2_out.s});
    xv[1] = X_W'(c2_out.side.mat_b);
    xv[2] = X_W'(c2_out.side.mat_c);
    xv[3] = X_W'(c2_out.side.mat_d) + $signed({2'b00, c2_out.s});
    for (int i = 0; i < 4; i++) begin
      mneg4_d[i]     = xv[i][X_W-1];
      xmag[i]        = mneg4_d[i] ? X_W'(-xv[i]) : X_W'(xv[i]);
      msat4_d[i]     = (CMP_W'(xmag[i]) >= (CMP_W'(t2) << SSH));
      dv4_d[i].rem   = DW'(xmag[i] >> SSH);
      dv4_d[i].den   = DW'(t2);
      dv4_d[i].tail  = {xmag[i][SSH-1:0], {MF{1'b0}}};
      dv4_d[i].quo   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv4_q   <= dv4_d;
      side4_q <= '{neg: mneg4_d, sat: msat4_d, ox: c2_out.side.shift_x,
                   oy: c2_out.side.shift_y, st: c2_out.st};
    end
  end

  // ---------------------------------------------------------------------------
  // Chain 3: matrix quotients (|x| * 2^F) / t, four lanes side by side.
  // ---------------------------------------------------------------------------
  aff_sqrt_pkg::dv_t c3_dv [4][QW+1];
  c3_t               c3_side_q [QW];
  logic [QW-1:0]     c3_v_q;

  for (genvar l = 0; l < 4; l++) begin : g_mlane
    assign c3_dv[l][0] = dv4_q[l];
    for (genvar g = 0; g < QW; g++) begin : g_cell
      aff_sqrt_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (c3_dv[l][g]),
        .q_o   (c3_dv[l][g+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_side_q[0] <= side4_q;
      for (int i = 1; i < QW; i++) begin
        c3_side_q[i] <= c3_side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: saturated root matrix, diagonal of m + I.
  // ---------------------------------------------------------------------------
  c3_t                        c3_out;
  aff_sqrt_pkg::word_t [3:0]  m5_d, m5_q;
  logic signed [P_W-1:0]      p00_5_q, p11_5_q;
  aff_sqrt_pkg::word_t        ox5_q, oy5_q;
  aff_sqrt_pkg::status_e      st5_q;
  logic                       v5_q;

  assign c3_out = c3_side_q[QW-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m5_d[i] = aff_sqrt_pkg::sat_word(c3_out.neg[i], c3_out.sat[i], c3_dv[i][QW].quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_q    <= m5_d;
      p00_5_q <= P_W'(m5_d[0]) + ONE_P;
      p11_5_q <= P_W'(m5_d[3]) + ONE_P;
      ox5_q   <= c3_out.ox;
      oy5_q   <= c3_out.oy;
      st5_q   <= c3_out.st;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: the six products for det(m + I) and the adjugate times offset.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]       pp6_q [6];
  aff_sqrt_pkg::word_t [3:0]  m6_q;
  aff_sqrt_pkg::status_e      st6_q;
  logic                       v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp6_q[0] <= PW'(p00_5_q) * PW'(p11_5_q);
      pp6_q[1] <= PW'(m5_q[1]) * PW'(m5_q[2]);
      pp6_q[2] <= PW'(p11_5_q) * PW'(ox5_q);
      pp6_q[3] <= PW'(m5_q[1]) * PW'(oy5_q);
      pp6_q[4] <= PW'(p00_5_q) * PW'(oy5_q);
      pp6_q[5] <= PW'(m5_q[2]) * PW'(ox5_q);
      m6_q     <= m5_q;
      st6_q    <= st5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: determinant and numerators, singular check.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]       detp7_d, detp7_q, nx7_q, ny7_q;
  aff_sqrt_pkg::word_t [3:0]  m7_q;
  aff_sqrt_pkg::status_e      st7_q;
  logic                       v7_q;

  assign detp7_d = pp6_q[0] - pp6_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      detp7_q <= detp7_d;
      nx7_q   <= pp6_q[2] - pp6_q[3];
      ny7_q   <= pp6_q[4] - pp6_q[5];
      m7_q    <= m6_q;
      if ((st6_q == aff_sqrt_pkg::ST_OK) && (detp7_d == PW'(0))) begin
        st7_q <= aff_sqrt_pkg::ST_SINGULAR;
      end else begin
        st7_q <= st6_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: offset lanes, magnitudes, saturation test, divider setup.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]          dmag;
  logic signed [PW-1:0]   num8 [2];
  logic [PW-1:0]          nmag [2];
  aff_sqrt_pkg::dv_t      dv8_d [2];
  aff_sqrt_pkg::dv_t      dv8_q [2];
  logic [1:0]             oneg8_d, osat8_d;
  c4_t                    side8_q;
  logic                   v8_q;

  always_comb begin
    dmag    = detp7_q[PW-1] ? PW'(-detp7_q) : PW'(detp7_q);
    num8[0] = nx7_q;
    num8[1] = ny7_q;
    for (int j = 0; j < 2; j++) begin
      nmag[j]       = num8[j][PW-1] ? PW'(-num8[j]) : PW'(num8[j]);
      oneg8_d[j]    = num8[j][PW-1] ^ detp7_q[PW-1];
      osat8_d[j]    = (CMP_W'(nmag[j]) >= (CMP_W'(dmag) << SSH));
      dv8_d[j].rem  = DW'(nmag[j] >> SSH);
      dv8_d[j].den  = DW'(dmag);
      dv8_d[j].tail = {nmag[j][SSH-1:0], {MF{1'b0}}};
      dv8_d[j].quo  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv8_q   <= dv8_d;
      side8_q <= '{m: m7_q, neg: oneg8_d, sat: osat8_d, st: st7_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Chain 4: offset quotients (|num| * 2^F) / |det(m + I)|, two lanes.
  // ---------------------------------------------------------------------------
  aff_sqrt_pkg::dv_t c4_dv [2][QW+1];
  c4_t               c4_side_q [QW];
  logic [QW-1:0]     c4_v_q;

  for (genvar l = 0; l < 2; l++) begin : g_olane
    assign c4_dv[l][0] = dv8_q[l];
    for (genvar g = 0; g < QW; g++) begin : g_cell
      aff_sqrt_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (c4_dv[l][g]),
        .q_o   (c4_dv[l][g+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_side_q[0] <= side8_q;
      for (int i = 1; i < QW; i++) begin
        c4_side_q[i] <= c4_side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: output register; any error status zeroes the fields.
  // ---------------------------------------------------------------------------
  c4_t                c4_out;
  aff_sqrt_pkg::out_t out_d, out_q;

  assign c4_out = c4_side_q[QW-1];

  always_comb begin
    out_d.root_a       = c4_out.m[0];
    out_d.root_b       = c4_out.m[1];
    out_d.root_c       = c4_out.m[2];
    out_d.root_d       = c4_out.m[3];
    out_d.root_shift_x = aff_sqrt_pkg::sat_word(c4_out.neg[0], c4_out.sat[0],
                                                c4_dv[0][QW].quo);
    out_d.root_shift_y = aff_sqrt_pkg::sat_word(c4_out.neg[1], c4_out.sat[1],
                                                c4_dv[1][QW].quo);
    out_d.status       = c4_out.st;
    if (c4_out.st != aff_sqrt_pkg::ST_OK) begin
      out_d              = '0;
      out_d.status       = c4_out.st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
  // Beat valid flags, one per register stage.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      c1_v_q <= '0;
      v3_q   <= 1'b0;
      c2_v_q <= '0;
      v4_q   <= 1'b0;
      c3_v_q <= '0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      c4_v_q <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      v0_q   <= in_valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      c1_v_q <= {c1_v_q[NSQ-2:0], v2_q};
      v3_q   <= c1_v_q[NSQ-1];
      c2_v_q <= {c2_v_q[NSQ-2:0], v3_q};
      v4_q   <= c2_v_q[NSQ-1];
      c3_v_q <= {c3_v_q[QW-2:0], v4_q};
      v5_q   <= c3_v_q[QW-1];
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      c4_v_q <= {c4_v_q[QW-2:0], v8_q};
      vout_q <= c4_v_q[QW-1];
    end
  end

endmodule

// File: dv/tb_affine2d_transform_sqrt.sv
// Testbench for the affine transform square root: random and directed beats vs a predictor.
`timescale 1ns / 100ps

module tb_affine2d_transform_sqrt;

  localparam int unsigned NUM_RANDOM  = 1000;
  localparam int unsigned QUIET_TAIL  = 120;   // final beats sent with no idling
  localparam int unsigned PIPE_CYCLES = 136;
  localparam int unsigned STALL_LIMIT = 5000;  // cycles with no beat accepted
  localparam int unsigned FRAC        = aff_sqrt_pkg::MATRIX_FRAC_BITS;

  typedef logic signed [127:0] wide_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  aff_sqrt_pkg::in_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  aff_sqrt_pkg::out_t out_data_o;

  aff_sqrt_pkg::in_t  xform_q[$];     // transforms waiting to be sent
  aff_sqrt_pkg::out_t root_q[$];      // predicted roots, oldest first
  int   n_sent, n_checked, n_errors, n_status[4];
  int   idle_in, idle_out, quiet_cycles;
  logic quiet;

  affine2d_transform_sqrt i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Floor square root; every radicand here is below 2^64, so the root fits 33 bits.
  function automatic wide_t floor_sqrt(wide_t v);
    wide_t res, cand;
    res = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = res | (wide_t'(1) << i);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // (num * 2^F) / den truncated toward zero, saturated to one word.
  function automatic aff_sqrt_pkg::word_t scaled_quot(wide_t num, wide_t den);
    logic  neg;
    wide_t mag;
    neg = (num < 0) != (den < 0);
    mag = ((num < 0 ? -num : num) << FRAC) / (den < 0 ? -den : den);
    if (mag >= (wide_t'(1) << 31)) begin
      return neg ? aff_sqrt_pkg::word_t'(32'h8000_0000) : aff_sqrt_pkg::word_t'(32'h7fff_ffff);
    end
    return neg ? aff_sqrt_pkg::word_t'(-mag) : aff_sqrt_pkg::word_t'(mag);
  endfunction

  function automatic aff_sqrt_pkg::out_t predict_root(aff_sqrt_pkg::in_t x);
    wide_t a, b, c, d, ox, oy, det, s, tr, t, ma, mb, mc, md, p00, p11, detp;
    aff_sqrt_pkg::out_t r;
    r = '0;
    r.status = aff_sqrt_pkg::ST_OK;
    a = x.mat_a; b = x.mat_b; c = x.mat_c; d = x.mat_d;
    ox = x.shift_x; oy = x.shift_y;
    det = a * d - b * c;
    if (det < 0) begin
      r.status = aff_sqrt_pkg::ST_NEG_DET;
      return r;
    end
    s  = floor_sqrt(det);
    tr = a + d + 2 * s;
    if (tr <= 0) begin
      r.status = aff_sqrt_pkg::ST_TRACE;
      return r;
    end
    t  = floor_sqrt(tr << FRAC);
    ma = scaled_quot(a + s, t);
    mb = scaled_quot(b, t);
    mc = scaled_quot(c, t);
    md = scaled_quot(d + s, t);
    p00  = ma + (wide_t'(1) << FRAC);
    p11  = md + (wide_t'(1) << FRAC);
    detp = p00 * p11 - mb * mc;
    if (detp == 0) begin
      r.status = aff_sqrt_pkg::ST_SINGULAR;
      return r;
    end
    r.root_a       = aff_sqrt_pkg::word_t'(ma);
    r.root_b       = aff_sqrt_pkg::word_t'(mb);
    r.root_c       = aff_sqrt_pkg::word_t'(mc);
    r.root_d       = aff_sqrt_pkg::word_t'(md);
    r.root_shift_x = scaled_quot(p11 * ox - mb * oy, detp);
    r.root_shift_y = scaled_quot(p00 * oy - mc * ox, detp);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("MISMATCH beat %0d %s: got %h expected %h", n_checked, field, got, want);
  endtask

  // Append one transform to the send queue.
  task automatic add_xform(aff_sqrt_pkg::word_t a, aff_sqrt_pkg::word_t b,
                           aff_sqrt_pkg::word_t c, aff_sqrt_pkg::word_t d,
                           aff_sqrt_pkg::word_t sx, aff_sqrt_pkg::word_t sy);
    aff_sqrt_pkg::in_t x;
    x = '{a, b, c, d, sx, sy};
    xform_q = {xform_q, x};
  endtask

  // Driver: next beat loaded whenever the slot is free, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      idle_in    <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (idle_in > 0) begin
        in_valid_i <= 1'b0;
        idle_in    <= idle_in - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        idle_in    <= $urandom_range(0, 5);
      end else if (xform_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= xform_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, independent of valid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      idle_out    <= 0;
    end else if (idle_out > 0) begin
      out_stall_i <= 1'b1;
      idle_out    <= idle_out - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      idle_out    <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each input beat, check each output beat, watch for hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        root_q = {root_q, predict_root(in_data_i)};
        n_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        aff_sqrt_pkg::out_t want;
        if (root_q.size() == 0) begin
          report_mismatch("unexpected beat", out_data_o.root_a, 32'h0);
        end else begin
          want = root_q.pop_front();
          n_status[want.status]++;
          if (out_data_o.root_a != want.root_a)
            report_mismatch("root_a", out_data_o.root_a, want.root_a);
          if (out_data_o.root_b != want.root_b)
            report_mismatch("root_b", out_data_o.root_b, want.root_b);
          if (out_data_o.root_c != want.root_c)
            report_mismatch("root_c", out_data_o.root_c, want.root_c);
          if (out_data_o.root_d != want.root_d)
            report_mismatch("root_d", out_data_o.root_d, want.root_d);
          if (out_data_o.root_shift_x != want.root_shift_x)
            report_mismatch("root_shift_x", out_data_o.root_shift_x, want.root_shift_x);
          if (out_data_o.root_shift_y != want.root_shift_y)
            report_mismatch("root_shift_y", out_data_o.root_shift_y, want.root_shift_y);
          if (out_data_o.status != want.status)
            report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        end
        n_checked++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    aff_sqrt_pkg::word_t one, a, b, c, d;
    one = aff_sqrt_pkg::word_t'(1 << FRAC);
    n_sent = 0; n_checked = 0; n_errors = 0; quiet_cycles = 0; quiet = 1'b0;
    n_status = '{0, 0, 0, 0};
    rst_ni = 1'b0;

    // Directed: identity, zero, negative determinant, field extremes, rotation.
    add_xform(one, 0, 0, one, 0, 0);
    add_xform(one, 0, 0, one, 32'h7fff_ffff, 32'h8000_0000);
    add_xform(0, 0, 0, 0, 123, -456);
    add_xform(one, one, one, -one, 1, 1);
    add_xform(-one, 0, 0, -one, 5, 5);
    add_xform(0, one, -one, 0, 32'h0001_0000, 0);
    add_xform(4 * one, 0, 0, 9 * one, 32'h0003_0000, 32'h7fff_ffff);
    add_xform(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, -1, 1);
    add_xform(32'h8000_0000, 0, 0, 32'h8000_0000, 7, -7);
    add_xform(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000);
    add_xform(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_xform(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, -1, -1);
    add_xform(1, 0, 0, 1, 1, 1);
    add_xform(0, 0, 0, 1, 0, 0);
    add_xform(-4 * one, one, -one, -4 * one, 100, 200);
    add_xform(one, 2 * one, 0, one, 32'h8000_0000, 32'h7fff_ffff);
    add_xform(2, 0, 0, -1, 3, 3);

    // Random: mostly well-conditioned matrices that reach the offset path, rest raw words.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_xform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        a = $urandom_range(0, 1 << 28) - (1 << 25);
        d = $urandom_range(0, 1 << 28) - (1 << 25);
        b = $signed($urandom) >>> $urandom_range(3, 31);
        c = $signed($urandom) >>> $urandom_range(3, 31);
        add_xform(a, b, c, d, $urandom, $urandom);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (xform_q.size() <= QUIET_TAIL);
    quiet = 1'b1;
    wait (xform_q.size() == 0 && !in_valid_i);
    wait (root_q.size() == 0);
    repeat (PIPE_CYCLES + 20) @(posedge clk_i);

    $display("Checked %0d of %0d transforms: %0d ok, %0d negative det, %0d trace, %0d singular",
             n_checked, n_sent, n_status[aff_sqrt_pkg::ST_OK],
             n_status[aff_sqrt_pkg::ST_NEG_DET], n_status[aff_sqrt_pkg::ST_TRACE],
             n_status[aff_sqrt_pkg::ST_SINGULAR]);
    $display("Input idling and output stall bursts on both sides, quiet tail at the end");
    if (n_errors == 0 && root_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
